FILE: rtl/kbc_pkg.sv
// shared types and constants of the kochanek-bartels curve sampler
package kbc_pkg;

  localparam int ONE_Q14 = 16384;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [15:0] tension;
    logic signed [15:0] bias;
    logic signed [15:0] continuity;
    logic               final_point;
  } in_t;

  typedef struct packed {
    logic signed [23:0] sample_x;
    logic signed [23:0] sample_y;
    logic               run_end;
    logic               curve_end;
  } out_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [15:0] t;
    logic signed [15:0] b;
    logic signed [15:0] c;
  } point_t;

  // one segment to blend, or the closing point when is_end is set
  typedef struct packed {
    point_t pv;
    point_t cu;
    point_t nx;
    point_t n2;
    logic   is_end;
    logic   last;
  } job_t;

endpackage

FILE: rtl/kbc_front.sv
// front end: point window, point count and segment job generation
module kbc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  kbc_pkg::in_t      in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output kbc_pkg::job_t     job
);

  kbc_pkg::point_t win_r [3];
  logic [1:0]      seen_r;
  kbc_pkg::point_t snap_r [4];
  logic [1:0]      sseen_r;
  logic            sfin_r;
  logic [2:0]      mask_r;
  logic [2:0]      mask_nxt;
  kbc_pkg::point_t newp;
  logic            accept;

  function automatic logic signed [15:0] clamp_tcb(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v > 16'(kbc_pkg::ONE_Q14)) r = 16'(kbc_pkg::ONE_Q14);
    else if (v < -16'(kbc_pkg::ONE_Q14)) r = -16'(kbc_pkg::ONE_Q14);
    return r;
  endfunction

  assign accept = push && !full;
  assign full   = |mask_r;

  always_comb begin
    newp.x = in_data.point_x;
    newp.y = in_data.point_y;
    newp.t = clamp_tcb(in_data.tension);
    newp.b = clamp_tcb(in_data.bias);
    newp.c = clamp_tcb(in_data.continuity);
  end

  // jobs are issued in order: inner segment, end segment, closing point
  always_comb begin
    job = '0;
    if (mask_r[0]) begin
      job.pv   = (sseen_r == 2'd3) ? snap_r[0] : snap_r[1];
      job.cu   = snap_r[1];
      job.nx   = snap_r[2];
      job.n2   = snap_r[3];
      job.last = !sfin_r;
    end else if (mask_r[1]) begin
      job.pv   = (sseen_r == 2'd1) ? snap_r[2] : snap_r[1];
      job.cu   = snap_r[2];
      job.nx   = snap_r[3];
      job.n2   = snap_r[3];
    end else begin
      job.pv     = snap_r[3];
      job.cu     = snap_r[3];
      job.nx     = snap_r[3];
      job.n2     = snap_r[3];
      job.is_end = 1'b1;
      job.last   = 1'b1;
    end
  end

  assign job_valid = |mask_r;

  always_comb begin
    mask_nxt = mask_r;
    if (job_valid && job_ready) begin
      if (mask_r[0])      mask_nxt[0] = 1'b0;
      else if (mask_r[1]) mask_nxt[1] = 1'b0;
      else                mask_nxt[2] = 1'b0;
    end
    if (accept) begin
      mask_nxt[0] = (seen_r >= 2'd2);
      mask_nxt[1] = in_data.final_point && (seen_r != 2'd0);
      mask_nxt[2] = in_data.final_point && (seen_r != 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      seen_r <= '0;
      for (int j = 0; j < 3; j++) win_r[j] <= '0;
    end else begin
      mask_r <= mask_nxt;
      if (accept) begin
        if (in_data.final_point) begin
          for (int j = 0; j < 3; j++) win_r[j] <= '0;
          seen_r <= '0;
        end else begin
          win_r[0] <= win_r[1];
          win_r[1] <= win_r[2];
          win_r[2] <= newp;
          if (seen_r != 2'd3) seen_r <= seen_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      snap_r[0] <= win_r[0];
      snap_r[1] <= win_r[1];
      snap_r[2] <= win_r[2];
      snap_r[3] <= newp;
      sseen_r   <= seen_r;
      sfin_r    <= in_data.final_point;
    end
  end

endmodule

FILE: rtl/kbc_queue.sv
// four-entry job queue between front end and blend engine
module kbc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  kbc_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output kbc_pkg::job_t rd_data
);

  kbc_pkg::job_t mem [4];
  logic [1:0]    wptr_r;
  logic [1:0]    rptr_r;
  logic [2:0]    cnt_r;
  logic          wr;
  logic          rd;

  assign wr_ready = (cnt_r != 3'd4);
  assign rd_valid = (cnt_r != 3'd0);
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;
  assign rd_data  = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr) wptr_r <= wptr_r + 2'd1;
      if (rd) rptr_r <= rptr_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr_r] <= wr_data;
  end

endmodule

FILE: rtl/kbc_back.sv
// blend engine: tangent setup, hermite sample pipeline, divider and result queue
module kbc_back #(
  parameter int SUBDIVS = 30
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  kbc_pkg::job_t job,
  output logic          empty,
  input  logic          pop,
  output kbc_pkg::out_t out_data
);

  localparam int    IW    = $clog2(SUBDIVS + 1);
  localparam int    S3    = SUBDIVS * SUBDIVS * SUBDIVS;
  localparam int    MW    = 24 + $clog2(S3 + 1);
  localparam longint HALF = longint'(S3) <<< 13;
  localparam longint LO_M = -(longint'(S3) <<< 23);
  localparam longint HI_M = (longint'(S3) <<< 23) - 1;
  localparam int    NDIV  = 3;

  // reciprocal of S3, exact for every dividend below 2^MW
  localparam int    KSH   = MW + $clog2(S3);
  localparam int    RW    = MW + 2;
  localparam int    HW    = (MW + 1) / 2;
  localparam int    PW    = MW + RW;
  localparam int    LLW   = 2 * HW;
  localparam int    HHW   = MW + RW - 2 * HW;
  localparam int    MDW   = RW + 1;
  localparam logic [RW-1:0] RCP =
    RW'(((longint'(1) <<< KSH) + longint'(S3) - 1) / longint'(S3));
  localparam logic [HW-1:0]    RCP_L = RCP[HW-1:0];
  localparam logic [RW-HW-1:0] RCP_H = RCP[RW-1:HW];

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_W1   = 3'd1;
  localparam logic [2:0] ST_W2   = 3'd2;
  localparam logic [2:0] ST_TAN  = 3'd3;
  localparam logic [2:0] ST_RUN  = 3'd4;

  typedef struct packed {
    logic signed [16:0] h00;
    logic signed [16:0] h01;
    logic signed [16:0] h10;
    logic signed [16:0] h11;
  } herm_t;

  typedef struct packed {
    logic run_end;
    logic curve_end;
  } flag_t;

  logic [2:0]         state_r;
  kbc_pkg::job_t      job_r;
  logic [IW-1:0]      i_r;
  logic [IW-1:0]      last_i;
  logic [31:0]        f12_r [4];
  logic [15:0]        f3_r [4];
  logic [16:0]        k_r [4];
  logic signed [24:0] dA_r [2];
  logic signed [24:0] dB_r [2];
  logic signed [24:0] dC_r [2];
  logic signed [43:0] m0_r [2];
  logic signed [43:0] m1_r [2];
  logic [46:0]        wp [4];
  logic signed [17:0] ks [4];

  logic               adv;
  logic               feed;

  // sample pipeline
  logic               v1_r, v2_r, v3_r, v4_r;
  flag_t              fl1_r, fl2_r, fl3_r, fl4_r;
  herm_t              h1_r;
  logic signed [23:0] p0_1_r [2];
  logic signed [23:0] p1_1_r [2];
  logic signed [43:0] m0_1_r [2];
  logic signed [43:0] m1_1_r [2];
  logic signed [40:0] hp0_r [2];
  logic signed [40:0] hp1_r [2];
  logic signed [60:0] hm0_r [2];
  logic signed [60:0] hm1_r [2];
  logic signed [63:0] tot_r [2];
  logic [MW-1:0]      mq_r [2];
  logic signed [63:0] mfl [2];
  logic signed [63:0] mcl [2];

  // divider stages
  logic               dv_r [NDIV];
  flag_t              dfl_r [NDIV];
  logic [LLW-1:0]     pll_r [2];
  logic [RW-1:0]      plh_r [2];
  logic [MW-1:0]      phl_r [2];
  logic [HHW-1:0]     phh_r [2];
  logic [LLW-1:0]     lo2_r [2];
  logic [MDW-1:0]     mid2_r [2];
  logic [HHW-1:0]     hi2_r [2];
  logic [PW-1:0]      prod [2];
  logic [23:0]        quo_r [2];

  // result queue
  kbc_pkg::out_t      ofifo [4];
  logic [1:0]         owp_r, orp_r;
  logic [2:0]         ocnt_r;
  logic               owr, ord;
  kbc_pkg::out_t      owdata;

  function automatic logic signed [23:0] coord(input kbc_pkg::point_t p, input int l);
    return (l == 0) ? p.x : p.y;
  endfunction

  function automatic logic [15:0] fm(input logic signed [15:0] v);
    logic signed [16:0] r;
    r = 17'(kbc_pkg::ONE_Q14) - 17'(v);
    return r[15:0];
  endfunction

  function automatic logic [15:0] fp(input logic signed [15:0] v);
    logic signed [16:0] r;
    r = 17'(kbc_pkg::ONE_Q14) + 17'(v);
    return r[15:0];
  endfunction

  function automatic herm_t herm(input logic [IW-1:0] i);
    logic signed [19:0] ii, i2, i3;
    herm_t h;
    ii = 20'(i);
    i2 = ii * ii;
    i3 = i2 * ii;
    h.h00 = 17'(2 * i3 - 3 * i2 * SUBDIVS + S3);
    h.h01 = 17'(-2 * i3 + 3 * i2 * SUBDIVS);
    h.h10 = 17'(i3 - 2 * i2 * SUBDIVS + ii * SUBDIVS * SUBDIVS);
    h.h11 = 17'(i3 - i2 * SUBDIVS);
    return h;
  endfunction

  assign job_ready = (state_r == ST_IDLE);
  assign adv       = (ocnt_r != 3'd4);
  assign feed      = (state_r == ST_RUN);
  assign last_i    = job_r.is_end ? '0 : IW'(SUBDIVS - 1);

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      wp[n] = 47'(f12_r[n]) * 47'(f3_r[n]) + 47'(1 << 28);
      ks[n] = $signed({1'b0, k_r[n]});
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (job_valid) state_r <= ST_W1;
        ST_W1:   state_r <= ST_W2;
        ST_W2:   state_r <= ST_TAN;
        ST_TAN: begin
          state_r <= ST_RUN;
          i_r     <= '0;
        end
        ST_RUN: begin
          if (adv) begin
            if (i_r == last_i) state_r <= ST_IDLE;
            else i_r <= i_r + IW'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // tangent setup
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && job_valid) job_r <= job;
    if (state_r == ST_W1) begin
      f12_r[0] <= 32'(fm(job_r.cu.t)) * 32'(fp(job_r.cu.b));
      f3_r[0]  <= fm(job_r.cu.c);
      f12_r[1] <= 32'(fm(job_r.cu.t)) * 32'(fm(job_r.cu.b));
      f3_r[1]  <= fp(job_r.cu.c);
      f12_r[2] <= 32'(fm(job_r.nx.t)) * 32'(fp(job_r.nx.b));
      f3_r[2]  <= fp(job_r.nx.c);
      f12_r[3] <= 32'(fm(job_r.nx.t)) * 32'(fm(job_r.nx.b));
      f3_r[3]  <= fm(job_r.nx.c);
      for (int l = 0; l < 2; l++) begin
        dA_r[l] <= 25'(coord(job_r.cu, l)) - 25'(coord(job_r.pv, l));
        dB_r[l] <= 25'(coord(job_r.nx, l)) - 25'(coord(job_r.cu, l));
        dC_r[l] <= 25'(coord(job_r.n2, l)) - 25'(coord(job_r.nx, l));
      end
    end
    if (state_r == ST_W2) begin
      for (int n = 0; n < 4; n++) k_r[n] <= wp[n][45:29];
    end
    if (state_r == ST_TAN) begin
      for (int l = 0; l < 2; l++) begin
        m0_r[l] <= 44'(ks[0]) * 44'(dA_r[l]) + 44'(ks[1]) * 44'(dB_r[l]);
        m1_r[l] <= 44'(ks[2]) * 44'(dB_r[l]) + 44'(ks[3]) * 44'(dC_r[l]);
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      for (int j = 0; j < NDIV; j++) dv_r[j] <= 1'b0;
    end else if (adv) begin
      v1_r <= feed;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      dv_r[0] <= v4_r;
      for (int j = 1; j < NDIV; j++) dv_r[j] <= dv_r[j-1];
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mfl[l] = tot_r[l] >>> 14;
      if (mfl[l] < LO_M)      mcl[l] = LO_M;
      else if (mfl[l] > HI_M) mcl[l] = HI_M;
      else                    mcl[l] = mfl[l];
    end
  end

  // division by the cube of the subdivision count: multiply by the reciprocal
  // in four partial products, then sum and take the top bits
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prod[l] = (PW'(hi2_r[l]) << (2 * HW)) + (PW'(mid2_r[l]) << HW) + PW'(lo2_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h1_r <= herm(i_r);
      fl1_r.run_end   <= job_r.last && (i_r == last_i);
      fl1_r.curve_end <= job_r.is_end;
      fl2_r <= fl1_r;
      fl3_r <= fl2_r;
      fl4_r <= fl3_r;
      dfl_r[0] <= fl4_r;
      for (int j = 1; j < NDIV; j++) dfl_r[j] <= dfl_r[j-1];
      for (int l = 0; l < 2; l++) begin
        p0_1_r[l] <= coord(job_r.cu, l);
        p1_1_r[l] <= coord(job_r.nx, l);
        m0_1_r[l] <= m0_r[l];
        m1_1_r[l] <= m1_r[l];
        hp0_r[l]  <= 41'(h1_r.h00) * 41'(p0_1_r[l]);
        hp1_r[l]  <= 41'(h1_r.h01) * 41'(p1_1_r[l]);
        hm0_r[l]  <= 61'(h1_r.h10) * 61'(m0_1_r[l]);
        hm1_r[l]  <= 61'(h1_r.h11) * 61'(m1_1_r[l]);
        tot_r[l]  <= ((64'(hp0_r[l]) + 64'(hp1_r[l])) <<< 14)
                     + 64'(hm0_r[l]) + 64'(hm1_r[l]) + HALF;
        mq_r[l]   <= MW'(mcl[l] - LO_M);
        pll_r[l]  <= LLW'(mq_r[l][HW-1:0]) * LLW'(RCP_L);
        plh_r[l]  <= RW'(mq_r[l][HW-1:0]) * RW'(RCP_H);
        phl_r[l]  <= MW'(mq_r[l][MW-1:HW]) * MW'(RCP_L);
        phh_r[l]  <= HHW'(mq_r[l][MW-1:HW]) * HHW'(RCP_H);
        lo2_r[l]  <= pll_r[l];
        mid2_r[l] <= MDW'(plh_r[l]) + MDW'(phl_r[l]);
        hi2_r[l]  <= phh_r[l];
        quo_r[l]  <= prod[l][KSH +: 24];
      end
    end
  end

  // result queue; quotient carries an offset of half the range
  assign owr   = adv && dv_r[NDIV-1];
  assign ord   = pop && !empty;
  assign empty = (ocnt_r == 3'd0);
  assign out_data = ofifo[orp_r];

  always_comb begin
    owdata.sample_x  = quo_r[0] ^ 24'h800000;
    owdata.sample_y  = quo_r[1] ^ 24'h800000;
    owdata.run_end   = dfl_r[NDIV-1].run_end;
    owdata.curve_end = dfl_r[NDIV-1].curve_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (owr) owp_r <= owp_r + 2'd1;
      if (ord) orp_r <= orp_r + 2'd1;
      ocnt_r <= ocnt_r + 3'(owr) - 3'(ord);
    end
  end

  always_ff @(posedge clk) begin
    if (owr) ofifo[owp_r] <= owdata;
  end

  a_close_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    owr && owdata.curve_end |-> owdata.run_end)
    else $error("closing sample without run end");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> i_r <= last_i)
    else $error("sample index past segment end");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv && state_r == ST_RUN |=> state_r == ST_RUN && $stable(i_r))
    else $error("sample index moved while stalled");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 3'd4)
    else $error("result queue overflow");

endmodule

FILE: rtl/kochanek_bartels_curve_sampler.sv
// top level of the kochanek-bartels curve sampler
//
// input channel: push/full with in_data; a control point transfers when push is
// high and full is low. result channel: empty/pop with out_data; the oldest
// sample is shown while empty is low and transfers when pop is high.
// each point after the second releases one segment of SUBDIVS samples; the
// final point releases the remaining one or two segments and the point itself.
// a segment job goes through pickup and tangent setup and then yields one
// sample per cycle while the result queue has room; the sample pipeline
// (hermite blend, rounding, 3 stages of reciprocal division) is 7 stages deep,
// and a sample enters the result queue from its last stage.
// the front end takes the next point once its jobs are queued.
// reset (synchronous, rst_n low) clears the window, point count, job queue,
// pipeline and result queue. when the receiver stops popping, the result
// queue fills, the sample pipeline freezes, then the job queue and finally
// full rises on the input side; nothing is dropped.
module kochanek_bartels_curve_sampler #(
  parameter int SUBDIVS = 30
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  kbc_pkg::in_t  in_data,
  output logic          empty,
  input  logic          pop,
  output kbc_pkg::out_t out_data
);

  logic          fj_valid, fj_ready;
  kbc_pkg::job_t fj;
  logic          bj_valid, bj_ready;
  kbc_pkg::job_t bj;

  kbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj)
  );

  kbc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fj_valid),
    .wr_ready (fj_ready),
    .wr_data  (fj),
    .rd_valid (bj_valid),
    .rd_ready (bj_ready),
    .rd_data  (bj)
  );

  kbc_back #(.SUBDIVS(SUBDIVS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (bj_valid),
    .job_ready (bj_ready),
    .job       (bj),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule
